/* rtl/isrf_pkg.sv */
// ----------------------------------------------------------------------------
// isrf_pkg
// Types and constants shared by the I2C slave register file core.
// ----------------------------------------------------------------------------
package isrf_pkg;

    // Bus event codes carried in the command field.
    localparam logic [2:0] CMD_START     = 3'd0;
    localparam logic [2:0] CMD_OVERFLOW  = 3'd1;
    localparam logic [2:0] CMD_STOP      = 3'd2;
    localparam logic [2:0] CMD_LOC_WRITE = 3'd3;
    localparam logic [2:0] CMD_LOC_READ  = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_SLAVE_ADDR  = 1'b0;
    localparam logic CFG_WRITE_MASKS = 1'b1;

    // Bytes loaded into the shift register for the acknowledge bit.
    localparam logic [7:0] BYTE_ACK = 8'h00;
    localparam logic [7:0] BYTE_NAK = 8'h80;

    // Bus state codes as reported on bus_state.
    localparam logic [1:0] BUS_ADDR  = 2'd0;
    localparam logic [1:0] BUS_PTR   = 2'd1;
    localparam logic [1:0] BUS_READ  = 2'd2;
    localparam logic [1:0] BUS_WRITE = 2'd3;

    typedef enum logic [3:0] {
        LINK_ADDR  = 4'b0001,
        LINK_PTR   = 4'b0010,
        LINK_READ  = 4'b0100,
        LINK_WRITE = 4'b1000
    } t_link;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data;
        logic [2:0] reg_index;
    } t_in;

    typedef struct packed {
        logic       shift_load;
        logic [7:0] shift_out;
        logic       drive_sda;
        logic       ack_phase_next;
        logic [1:0] bus_state;
        logic       stop_seen;
        logic [7:0] updates_reported;
        logic [7:0] read_value;
    } t_out;

    // One write into the register file: bits set in mask take data.
    typedef struct packed {
        logic       en;
        logic [2:0] addr;
        logic [7:0] data;
        logic [7:0] mask;
    } t_rf_wr;

endpackage

/* rtl/isrf_regfile.sv */
// ----------------------------------------------------------------------------
// isrf_regfile
// Bank of eight-bit registers with one bit-masked write port and one
// combinational read port.
// ----------------------------------------------------------------------------
module isrf_regfile #(
    parameter int NUM_REGS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  isrf_pkg::t_rf_wr     i_wr,
    input  logic [2:0]           i_rd_addr,
    output logic [7:0]           o_rd_data
);

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    logic [7:0] r_regs [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else if (i_wr.en) begin
            r_regs[i_wr.addr[IDX_W-1:0]] <=
                (r_regs[i_wr.addr[IDX_W-1:0]] & ~i_wr.mask) | (i_wr.data & i_wr.mask);
        end
    end

    assign o_rd_data = r_regs[i_rd_addr[IDX_W-1:0]];

endmodule

/* rtl/i2c_slave_register_file_core.sv */
// ----------------------------------------------------------------------------
// i2c_slave_register_file_core
// Byte-level I2C slave protocol engine with a small masked register file.
// ----------------------------------------------------------------------------
// Each bus event beat is captured in an input register, handled in one pass
// of logic against the link state and the register file, and written to a
// result register. The core accepts one beat per clock while results are
// taken; a beat waits in r_in and its result is registered in r_out. While a
// finished result waits to be taken, the input register holds at most one
// further beat, and the input then stalls until the result is taken. The
// single pass through the register file read port and write merge sets the
// one-beat-per-cycle figure. Configuration writes are always accepted.
module i2c_slave_register_file_core #(
    parameter int NUM_REGS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,

    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  isrf_pkg::t_in   i_in,

    output logic            o_out_valid,
    input  logic            i_out_ready,
    output isrf_pkg::t_out  o_out,

    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_cfg_index,
    input  logic [63:0]     i_cfg_data
);

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [7:0]       LAST_REG = 8'(NUM_REGS - 1);
    localparam logic [IDX_W-1:0] LAST_OFF = IDX_W'(NUM_REGS - 1);
    localparam logic [3:0]       REG_COUNT = 4'(NUM_REGS);

    // Configuration
    logic [6:0]  r_slave_addr;
    logic [63:0] r_write_masks;

    // Pipeline registers
    logic            r_in_valid;
    isrf_pkg::t_in   r_in;
    logic            r_out_valid;
    isrf_pkg::t_out  r_out;
    isrf_pkg::t_out  n_out;

    // Protocol state
    isrf_pkg::t_link  r_link,   n_link;
    logic             r_post,   n_post;
    logic [IDX_W-1:0] r_offset, n_offset;
    logic [7:0]       r_count,  n_count;

    isrf_pkg::t_rf_wr rf_wr;
    logic [2:0]       rf_rd_addr;
    logic [7:0]       rf_rd_data;

    logic             advance;
    logic [IDX_W-1:0] offset_inc;
    logic [7:0]       cur_mask;
    logic             idx_ok;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign offset_inc = (r_offset == LAST_OFF) ? '0 : r_offset + IDX_W'(1);
    assign cur_mask   = r_write_masks[{3'(r_offset), 3'b000} +: 8];
    assign idx_ok     = {1'b0, r_in.reg_index} < REG_COUNT;

    // A local read addresses the register file by index; every other beat
    // uses the streaming offset.
    assign rf_rd_addr = (r_in.command == isrf_pkg::CMD_LOC_READ)
                      ? r_in.reg_index : 3'(r_offset);

    isrf_regfile #(
        .NUM_REGS (NUM_REGS)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (rf_wr),
        .i_rd_addr (rf_rd_addr),
        .o_rd_data (rf_rd_data)
    );

    function automatic logic [1:0] link_code(isrf_pkg::t_link link);
        logic [1:0] code;
        unique case (link)
            isrf_pkg::LINK_ADDR:  code = isrf_pkg::BUS_ADDR;
            isrf_pkg::LINK_PTR:   code = isrf_pkg::BUS_PTR;
            isrf_pkg::LINK_READ:  code = isrf_pkg::BUS_READ;
            isrf_pkg::LINK_WRITE: code = isrf_pkg::BUS_WRITE;
            default:              code = isrf_pkg::BUS_ADDR;
        endcase
        return code;
    endfunction

    always_comb begin
        n_link   = r_link;
        n_post   = r_post;
        n_offset = r_offset;
        n_count  = r_count;
        n_out    = '0;
        rf_wr    = '0;

        unique case (r_in.command)
            isrf_pkg::CMD_START: begin
                n_link = isrf_pkg::LINK_ADDR;
                n_post = 1'b0;
            end
            isrf_pkg::CMD_OVERFLOW: begin
                if (!r_post) begin
                    // End of a data byte: answer with the acknowledge bit.
                    n_out.shift_load = 1'b1;
                    n_out.drive_sda  = 1'b1;
                    n_post           = 1'b1;
                    unique case (r_link)
                        isrf_pkg::LINK_ADDR: begin
                            if (r_in.data[7:1] != 7'd0 && r_in.data[7:1] != r_slave_addr) begin
                                n_out.shift_out = isrf_pkg::BYTE_NAK;
                            end else begin
                                n_out.shift_out = isrf_pkg::BYTE_ACK;
                                if (r_in.data[0]) begin
                                    n_link = isrf_pkg::LINK_READ;
                                end else begin
                                    n_link   = isrf_pkg::LINK_PTR;
                                    n_offset = '0;
                                end
                            end
                        end
                        isrf_pkg::LINK_PTR: begin
                            if (r_in.data > LAST_REG) begin
                                n_link          = isrf_pkg::LINK_ADDR;
                                n_out.shift_out = isrf_pkg::BYTE_NAK;
                            end else begin
                                n_link          = isrf_pkg::LINK_WRITE;
                                n_offset        = r_in.data[IDX_W-1:0];
                                n_out.shift_out = isrf_pkg::BYTE_ACK;
                            end
                        end
                        isrf_pkg::LINK_READ: begin
                            // The master acknowledges; the slave releases SDA.
                            n_out.shift_out = 8'h00;
                            n_out.drive_sda = 1'b0;
                        end
                        default: begin
                            if (cur_mask != 8'h00) begin
                                rf_wr.en   = 1'b1;
                                rf_wr.addr = 3'(r_offset);
                                rf_wr.data = r_in.data;
                                rf_wr.mask = cur_mask;
                                n_count    = r_count + 8'd1;
                            end
                            n_offset        = offset_inc;
                            n_out.shift_out = isrf_pkg::BYTE_ACK;
                        end
                    endcase
                end else begin
                    n_post = 1'b0;
                    if (r_link == isrf_pkg::LINK_READ) begin
                        if (r_in.data != 8'h00) begin
                            // The master NAKed: the read stream ends.
                            n_offset = '0;
                            n_link   = isrf_pkg::LINK_ADDR;
                        end else begin
                            n_out.shift_load = 1'b1;
                            n_out.drive_sda  = 1'b1;
                            n_out.shift_out  = rf_rd_data;
                            n_offset         = offset_inc;
                        end
                    end
                end
            end
            isrf_pkg::CMD_STOP: begin
                if (r_link == isrf_pkg::LINK_WRITE && r_count != 8'd0) begin
                    n_offset = '0;
                end
                n_link                 = isrf_pkg::LINK_ADDR;
                n_out.stop_seen        = 1'b1;
                n_out.updates_reported = r_count;
                n_count                = 8'd0;
            end
            isrf_pkg::CMD_LOC_WRITE: begin
                if (idx_ok) begin
                    rf_wr.en   = 1'b1;
                    rf_wr.addr = r_in.reg_index;
                    rf_wr.data = r_in.data;
                    rf_wr.mask = 8'hFF;
                end
            end
            isrf_pkg::CMD_LOC_READ: begin
                if (idx_ok) begin
                    n_out.read_value = rf_rd_data;
                end
            end
            default: begin
            end
        endcase

        n_out.ack_phase_next = n_post;
        n_out.bus_state      = link_code(n_link);

        // The register file only changes for a beat that is being handled.
        rf_wr.en = rf_wr.en && advance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_link      <= isrf_pkg::LINK_ADDR;
            r_post      <= 1'b0;
            r_offset    <= '0;
            r_count     <= 8'd0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_link      <= n_link;
                r_post      <= n_post;
                r_offset    <= n_offset;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr  <= 7'd0;
            r_write_masks <= 64'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                isrf_pkg::CFG_SLAVE_ADDR:  r_slave_addr  <= i_cfg_data[6:0];
                isrf_pkg::CFG_WRITE_MASKS: r_write_masks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule
